// ===== sv/tlsni_pkg.sv =====
// shared types and constants for the tls client hello server name extractor
`default_nettype none

package tlsni_pkg;

    localparam int unsigned POS_W = 17;
    localparam int unsigned OFF_W = 18;
    localparam int unsigned SUM_W = 20;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    localparam logic [7:0]  REC_HANDSHAKE   = 8'h16;
    localparam logic [7:0]  HS_CLIENT_HELLO = 8'h01;
    localparam logic [15:0] EXT_SERVER_NAME = 16'h0000;
    localparam logic [7:0]  MAX_NAME_RESET  = 8'd200;

    // longest payload that is still too short to hold a client hello up to the session id
    localparam logic [15:0] MIN_PAYLOAD_LEN = 16'd43;
    // offsets of the handshake type and of the session id length byte
    localparam logic [OFF_W-1:0] HS_TYPE_OFFSET = 18'd5;
    localparam logic [OFF_W-1:0] SID_OFFSET     = 18'd43;

    typedef enum logic [14:0] {
        PH_TYPE  = 15'h0001,
        PH_HS    = 15'h0002,
        PH_SID   = 15'h0004,
        PH_CS_HI = 15'h0008,
        PH_CS_LO = 15'h0010,
        PH_CM    = 15'h0020,
        PH_XL_HI = 15'h0040,
        PH_XL_LO = 15'h0080,
        PH_ET_HI = 15'h0100,
        PH_ET_LO = 15'h0200,
        PH_EL_HI = 15'h0400,
        PH_EL_LO = 15'h0800,
        PH_NL_HI = 15'h1000,
        PH_NL_LO = 15'h2000,
        PH_COPY  = 15'h4000
    } phase_t;

    typedef struct packed {
        logic [POS_W-1:0] byte_position;
        phase_t           parse_phase;
        logic [OFF_W-1:0] next_field_offset;
        logic [OFF_W-1:0] extensions_end;
        logic [7:0]       field_accumulator;
        logic             extension_is_name;
        logic [7:0]       name_bytes_left;
        logic             decided;
    } pstate_t;

    localparam pstate_t PSTATE_RESET = '{
        byte_position:     '0,
        parse_phase:       PH_TYPE,
        next_field_offset: '0,
        extensions_end:    '0,
        field_accumulator: '0,
        extension_is_name: 1'b0,
        name_bytes_left:   '0,
        decided:           1'b0
    };

    typedef struct packed {
        logic       emit;
        logic [7:0] name_byte;
        logic       byte_valid;
        logic       done_res;
        logic       found;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/tls_client_hello_sni_extract_core.sv =====
// top level of the tls client hello server name extractor
`default_nettype none

// channel   | handshake                  | payload
// ----------+----------------------------+----------------------------------------------
// item      | item_valid, item_stall     | data_byte, payload_length, last_byte
// result    | result_valid, result_stall | name_byte, byte_valid, done_res, found
// config    | cfg_write_en               | cfg_write_data (max_name_length)
//
// one payload byte per cycle sustained while the result side does not stall; once its byte is
// accepted, a result passes through the byte register and then the result register
// the byte register feeds one parser step whose next state is registered back as its state
// a stalled result holds the byte register, which then stalls the item side
// reset clears the parser, the pipeline valid flags and sets max_name_length to 200
// bytes that cause no result pass through the byte register without one

module tls_client_hello_sni_extract_core (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic [15:0] payload_length,
    input  wire logic        last_byte,

    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [7:0]       name_byte,
    output logic             byte_valid,
    output logic             done_res,
    output logic             found,

    input  wire logic        cfg_write_en,
    input  wire logic [7:0]  cfg_write_data
);

    // byte register
    logic        byte_valid_reg;
    logic [7:0]  data_reg;
    logic [15:0] plen_reg;
    logic        last_reg;

    // configuration
    logic [7:0]  max_len_reg;

    // parser state and step outputs
    tlsni_pkg::pstate_t st_reg;
    tlsni_pkg::pstate_t st_next;
    tlsni_pkg::result_t step_res;

    // result register
    logic        res_valid_reg;
    logic [7:0]  res_name_reg;
    logic        res_bv_reg;
    logic        res_done_reg;
    logic        res_found_reg;

    logic out_free;
    logic step_fire;
    logic item_take;

    // result register can take a new transaction this cycle
    assign out_free  = !res_valid_reg || !result_stall;
    assign step_fire = byte_valid_reg && out_free;
    assign item_stall = byte_valid_reg && !out_free;
    assign item_take = item_valid && !item_stall;

    tlsni_step u_step (
        .st_cur          (st_reg),
        .data_byte       (data_reg),
        .payload_length  (plen_reg),
        .last_byte       (last_reg),
        .max_name_length (max_len_reg),
        .st_next         (st_next),
        .res             (step_res)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            st_reg         <= tlsni_pkg::PSTATE_RESET;
            max_len_reg    <= tlsni_pkg::MAX_NAME_RESET;
        end
        else
        begin
            if (cfg_write_en)
                max_len_reg <= cfg_write_data;

            if (item_take)
                byte_valid_reg <= 1'b1;
            else if (step_fire)
                byte_valid_reg <= 1'b0;

            if (step_fire)
                st_reg <= st_next;

            if (step_fire)
                res_valid_reg <= step_res.emit;
            else if (out_free)
                res_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            data_reg <= data_byte;
            plen_reg <= payload_length;
            last_reg <= last_byte;
        end
        if (step_fire && step_res.emit)
        begin
            res_name_reg  <= step_res.name_byte;
            res_bv_reg    <= step_res.byte_valid;
            res_done_reg  <= step_res.done_res;
            res_found_reg <= step_res.found;
        end
    end

    assign result_valid = res_valid_reg;
    assign name_byte    = res_name_reg;
    assign byte_valid   = res_bv_reg;
    assign done_res     = res_done_reg;
    assign found        = res_found_reg;

`ifndef SYNTH
    // found only ever travels with the end of the search
    a_found_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && found |-> done_res)
        else $error("found without done_res");

    // an empty name slot carries a zero byte
    a_empty_name_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !byte_valid |-> name_byte == 8'd0)
        else $error("name_byte not zero with byte_valid low");

    // once decided, bytes before the last byte of the packet give no result
    a_decided_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire && st_reg.decided && !last_reg |=> !res_valid_reg)
        else $error("result after the search was decided");
`endif

endmodule

`default_nettype wire

// ===== sv/tlsni_step.sv =====
// per-byte parser step: next parser state and the result of one payload byte
`default_nettype none

module tlsni_step (
    input  wire tlsni_pkg::pstate_t st_cur,
    input  wire logic [7:0]         data_byte,
    input  wire logic [15:0]        payload_length,
    input  wire logic               last_byte,
    input  wire logic [7:0]         max_name_length,
    output tlsni_pkg::pstate_t      st_next,
    output tlsni_pkg::result_t      res
);

    always_comb
    begin
        logic [tlsni_pkg::SUM_W-1:0] p_w;
        logic [tlsni_pkg::SUM_W-1:0] plen_w;
        logic [tlsni_pkg::SUM_W-1:0] p1;
        logic [tlsni_pkg::SUM_W-1:0] pd1;
        logic [tlsni_pkg::SUM_W-1:0] pv1;
        logic [tlsni_pkg::SUM_W-1:0] lc_off;
        logic [tlsni_pkg::SUM_W-1:0] lc_end;
        logic [15:0]                 v;
        logic [7:0]                  cnt;
        logic [7:0]                  left_dec;
        logic                        match;
        logic                        fail;
        logic                        win;
        logic                        lc_ok;

        st_next = st_cur;
        res     = '0;
        fail    = 1'b0;
        win     = 1'b0;

        v      = {st_cur.field_accumulator, data_byte};
        p_w    = tlsni_pkg::SUM_W'(st_cur.byte_position);
        plen_w = tlsni_pkg::SUM_W'(payload_length);
        p1     = p_w + tlsni_pkg::SUM_W'(1);
        pd1    = p1 + tlsni_pkg::SUM_W'(data_byte);
        pv1    = p1 + tlsni_pkg::SUM_W'(v);
        match  = !st_cur.decided &&
                 (tlsni_pkg::OFF_W'(st_cur.byte_position) == st_cur.next_field_offset);

        // next extension header must fit in both the extension block and the payload
        if (st_cur.parse_phase == tlsni_pkg::PH_XL_LO)
        begin
            lc_off = p1;
            lc_end = pv1;
        end
        else
        begin
            lc_off = pv1;
            lc_end = tlsni_pkg::SUM_W'(st_cur.extensions_end);
        end
        lc_ok = (lc_off + tlsni_pkg::SUM_W'(4) < lc_end) &&
                (lc_off + tlsni_pkg::SUM_W'(4) < plen_w);

        cnt      = (v < 16'(max_name_length)) ? v[7:0] : max_name_length;
        left_dec = st_cur.name_bytes_left - 8'd1;

        if (match)
        begin
            case (st_cur.parse_phase)
                tlsni_pkg::PH_TYPE:
                begin
                    if (payload_length <= tlsni_pkg::MIN_PAYLOAD_LEN ||
                        data_byte != tlsni_pkg::REC_HANDSHAKE)
                        fail = 1'b1;
                    else
                    begin
                        st_next.parse_phase       = tlsni_pkg::PH_HS;
                        st_next.next_field_offset = tlsni_pkg::HS_TYPE_OFFSET;
                    end
                end
                tlsni_pkg::PH_HS:
                begin
                    if (data_byte != tlsni_pkg::HS_CLIENT_HELLO)
                        fail = 1'b1;
                    else
                    begin
                        st_next.parse_phase       = tlsni_pkg::PH_SID;
                        st_next.next_field_offset = tlsni_pkg::SID_OFFSET;
                    end
                end
                tlsni_pkg::PH_SID, tlsni_pkg::PH_CM:
                begin
                    if (pd1 + tlsni_pkg::SUM_W'(2) >= plen_w)
                        fail = 1'b1;
                    else
                    begin
                        st_next.parse_phase = (st_cur.parse_phase == tlsni_pkg::PH_SID) ?
                                              tlsni_pkg::PH_CS_HI : tlsni_pkg::PH_XL_HI;
                        st_next.next_field_offset = pd1[tlsni_pkg::OFF_W-1:0];
                    end
                end
                tlsni_pkg::PH_CS_HI, tlsni_pkg::PH_XL_HI, tlsni_pkg::PH_ET_HI,
                tlsni_pkg::PH_EL_HI, tlsni_pkg::PH_NL_HI:
                begin
                    // the low byte phase is the next one-hot code
                    st_next.field_accumulator = data_byte;
                    st_next.parse_phase       = tlsni_pkg::phase_t'(st_cur.parse_phase << 1);
                    st_next.next_field_offset = p1[tlsni_pkg::OFF_W-1:0];
                end
                tlsni_pkg::PH_CS_LO:
                begin
                    if (pv1 + tlsni_pkg::SUM_W'(1) >= plen_w)
                        fail = 1'b1;
                    else
                    begin
                        st_next.parse_phase       = tlsni_pkg::PH_CM;
                        st_next.next_field_offset = pv1[tlsni_pkg::OFF_W-1:0];
                    end
                end
                tlsni_pkg::PH_XL_LO, tlsni_pkg::PH_EL_LO:
                begin
                    if (st_cur.parse_phase == tlsni_pkg::PH_XL_LO)
                        st_next.extensions_end = pv1[tlsni_pkg::OFF_W-1:0];
                    if (!lc_ok)
                        fail = 1'b1;
                    else
                    begin
                        st_next.parse_phase       = tlsni_pkg::PH_ET_HI;
                        st_next.next_field_offset = lc_off[tlsni_pkg::OFF_W-1:0];
                    end
                end
                tlsni_pkg::PH_ET_LO:
                begin
                    st_next.extension_is_name = (v == tlsni_pkg::EXT_SERVER_NAME);
                    if (v == tlsni_pkg::EXT_SERVER_NAME)
                    begin
                        // skip ext length, list length and name type
                        if (p_w + tlsni_pkg::SUM_W'(8) >= plen_w)
                            fail = 1'b1;
                        else
                        begin
                            st_next.parse_phase       = tlsni_pkg::PH_NL_HI;
                            st_next.next_field_offset =
                                tlsni_pkg::OFF_W'(p_w + tlsni_pkg::SUM_W'(6));
                        end
                    end
                    else
                    begin
                        st_next.parse_phase       = tlsni_pkg::PH_EL_HI;
                        st_next.next_field_offset = p1[tlsni_pkg::OFF_W-1:0];
                    end
                end
                tlsni_pkg::PH_NL_LO:
                begin
                    if (pv1 > plen_w)
                        fail = 1'b1;
                    else if (cnt == 8'd0)
                        win = 1'b1;
                    else
                    begin
                        st_next.name_bytes_left   = cnt;
                        st_next.parse_phase       = tlsni_pkg::PH_COPY;
                        st_next.next_field_offset = p1[tlsni_pkg::OFF_W-1:0];
                    end
                end
                tlsni_pkg::PH_COPY:
                begin
                    // a zero byte ends the name early
                    if (data_byte == 8'd0)
                        win = 1'b1;
                    else
                    begin
                        res.emit                = 1'b1;
                        res.name_byte           = data_byte;
                        res.byte_valid          = 1'b1;
                        st_next.name_bytes_left = left_dec;
                        if (left_dec == 8'd0)
                            win = 1'b1;
                        else
                            st_next.next_field_offset = p1[tlsni_pkg::OFF_W-1:0];
                    end
                end
                default:
                begin
                    fail = 1'b1;
                end
            endcase
        end

        if (fail || win)
        begin
            res.emit        = 1'b1;
            res.done_res    = 1'b1;
            res.found       = win;
            st_next.decided = 1'b1;
        end

        // packet ends with no decision
        if (last_byte && !st_next.decided)
        begin
            res.emit     = 1'b1;
            res.done_res = 1'b1;
            res.found    = (st_next.parse_phase == tlsni_pkg::PH_COPY);
        end

        if (last_byte)
            st_next = tlsni_pkg::PSTATE_RESET;
        else if (st_cur.byte_position != tlsni_pkg::POS_MAX)
            st_next.byte_position = st_cur.byte_position + 1'b1;
        else
            st_next.byte_position = st_cur.byte_position;
    end

endmodule

`default_nettype wire

// ===== tb/sv/sni_scoreboard_pkg.sv =====
// scoreboard class with a byte-level model of the server name extractor
`timescale 1ns / 100ps

package sni_scoreboard_pkg;

    import tlsni_pkg::*;

    class sni_scoreboard;
        logic [7:0]       max_name_len;
        logic [POS_W-1:0] position;
        phase_t           phase;
        logic [OFF_W-1:0] target_offset;
        logic [OFF_W-1:0] ext_list_end;
        logic [7:0]       length_hi;
        logic             in_name_ext;
        logic [7:0]       name_left;
        logic             settled;
        result_t          expected_name_events[$];
        int unsigned      mismatches;
        int unsigned      checked;
        int unsigned      parsed_bytes;
        int unsigned      names_found;
        int unsigned      searches_failed;
        int unsigned      name_chars;

        function new();
            mismatches = 0;
            checked = 0;
            parsed_bytes = 0;
            names_found = 0;
            searches_failed = 0;
            name_chars = 0;
            max_name_len = MAX_NAME_RESET;
            restart();
        endfunction

        function void restart();
            position = '0;
            phase = PH_TYPE;
            target_offset = '0;
            ext_list_end = '0;
            length_hi = '0;
            in_name_ext = 1'b0;
            name_left = '0;
            settled = 1'b0;
        endfunction

        function void set_max_name_len(logic [7:0] value);
            max_name_len = value;
        endfunction

        function int unsigned pending();
            return expected_name_events.size();
        endfunction

        // next extension header must lie inside both the list and the payload
        function bit extension_fits(int unsigned start, int unsigned plen);
            if (start + 4 < ext_list_end && start + 4 < plen)
            begin
                phase = PH_ET_HI;
                target_offset = OFF_W'(start);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_byte(logic [7:0] data, logic [15:0] plen, logic last);
            int unsigned p;
            int unsigned v;
            int unsigned off;
            int unsigned cnt;
            bit fail;
            bit win;
            bit emit;
            result_t r;
            p = position;
            r = '0;
            fail = 1'b0;
            win = 1'b0;
            emit = 1'b0;
            if (!settled && p == target_offset)
            begin
                parsed_bytes++;
                v = {length_hi, data};
                case (phase)
                    PH_TYPE:
                        if (plen <= MIN_PAYLOAD_LEN || data != REC_HANDSHAKE)
                            fail = 1'b1;
                        else
                        begin
                            phase = PH_HS;
                            target_offset = HS_TYPE_OFFSET;
                        end
                    PH_HS:
                        if (data != HS_CLIENT_HELLO)
                            fail = 1'b1;
                        else
                        begin
                            phase = PH_SID;
                            target_offset = SID_OFFSET;
                        end
                    PH_SID:
                    begin
                        off = p + 1 + data;
                        if (off + 2 >= plen)
                            fail = 1'b1;
                        else
                        begin
                            phase = PH_CS_HI;
                            target_offset = OFF_W'(off);
                        end
                    end
                    PH_CS_HI, PH_XL_HI, PH_ET_HI, PH_EL_HI, PH_NL_HI:
                    begin
                        length_hi = data;
                        phase = phase_t'({phase[13:0], 1'b0});
                        target_offset = OFF_W'(p + 1);
                    end
                    PH_CS_LO:
                    begin
                        off = p + 1 + v;
                        if (off + 1 >= plen)
                            fail = 1'b1;
                        else
                        begin
                            phase = PH_CM;
                            target_offset = OFF_W'(off);
                        end
                    end
                    PH_CM:
                    begin
                        off = p + 1 + data;
                        if (off + 2 >= plen)
                            fail = 1'b1;
                        else
                        begin
                            phase = PH_XL_HI;
                            target_offset = OFF_W'(off);
                        end
                    end
                    PH_XL_LO:
                    begin
                        off = p + 1;
                        ext_list_end = OFF_W'(off + v);
                        if (!extension_fits(off, plen))
                            fail = 1'b1;
                    end
                    PH_ET_LO:
                    begin
                        in_name_ext = (v == 0);
                        if (in_name_ext)
                        begin
                            if (p + 8 >= plen)
                                fail = 1'b1;
                            else
                            begin
                                // skip extension and list lengths and the name type
                                phase = PH_NL_HI;
                                target_offset = OFF_W'(p + 6);
                            end
                        end
                        else
                        begin
                            phase = PH_EL_HI;
                            target_offset = OFF_W'(p + 1);
                        end
                    end
                    PH_EL_LO:
                        if (!extension_fits(p + 1 + v, plen))
                            fail = 1'b1;
                    PH_NL_LO:
                    begin
                        off = p + 1;
                        if (off + v > plen)
                            fail = 1'b1;
                        else
                        begin
                            cnt = (v < max_name_len) ? v : max_name_len;
                            if (cnt == 0)
                                win = 1'b1;
                            else
                            begin
                                name_left = cnt[7:0];
                                phase = PH_COPY;
                                target_offset = OFF_W'(off);
                            end
                        end
                    end
                    PH_COPY:
                        if (data == 8'h00)
                            win = 1'b1;
                        else
                        begin
                            emit = 1'b1;
                            r.name_byte = data;
                            r.byte_valid = 1'b1;
                            name_left = name_left - 8'd1;
                            if (name_left == 8'd0)
                                win = 1'b1;
                            else
                                target_offset = OFF_W'(p + 1);
                        end
                    default:
                        fail = 1'b1;
                endcase
            end

            if (fail)
            begin
                emit = 1'b1;
                r.done_res = 1'b1;
                settled = 1'b1;
            end
            else if (win)
            begin
                emit = 1'b1;
                r.done_res = 1'b1;
                r.found = 1'b1;
                settled = 1'b1;
            end

            // packet closes before any decision
            if (last && !settled)
            begin
                emit = 1'b1;
                r.done_res = 1'b1;
                r.found = (phase == PH_COPY);
            end

            if (last)
                restart();
            else if (position < POS_MAX)
                position = position + 1'b1;

            if (emit)
            begin
                r.emit = 1'b1;
                if (r.done_res && r.found)
                    names_found++;
                if (r.done_res && !r.found)
                    searches_failed++;
                if (r.byte_valid)
                    name_chars++;
                expected_name_events.push_back(r);
            end
        endfunction

        function void compare_field(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                mismatches++;
                $error("%s mismatch: expected 0x%02h, actual 0x%02h", field, want, got);
            end
        endfunction

        function void check_result(logic [7:0] nb, logic bv, logic dn, logic fd);
            result_t want;
            if (expected_name_events.size() == 0)
            begin
                mismatches++;
                $error("result transaction with nothing expected: name_byte 0x%02h %0b%0b%0b",
                       nb, bv, dn, fd);
                return;
            end
            want = expected_name_events.pop_front();
            checked++;
            compare_field("name_byte", want.name_byte, nb);
            compare_field("byte_valid", want.byte_valid, bv);
            compare_field("done_res", want.done_res, dn);
            compare_field("found", want.found, fd);
        endfunction
    endclass

endpackage

// ===== tb/sv/tls_client_hello_sni_extract_core_test.sv =====
// top-level testbench for the tls client hello server name extractor
`timescale 1ns / 100ps

module tls_client_hello_sni_extract_core_test;

    import tlsni_pkg::*;
    import sni_scoreboard_pkg::*;

    // bytes sent over the whole run, spread evenly across the random phases
    localparam int unsigned ITEM_TARGET  = 1400;
    localparam int unsigned PHASES       = 6;
    // watchdog limit, well above a run even when the last packet of a phase is long
    localparam int unsigned CYCLE_LIMIT  = 50_000;
    // idle wait after the last expected result, for bytes still in the byte register with no result
    localparam int unsigned DRAIN_CYCLES = 8;

    // ways a generated hello gets damaged before it is sent
    typedef enum int unsigned {
        FLAW_NONE,
        FLAW_FLIP,
        FLAW_ANY_LEN,
        FLAW_SHORT_LEN,
        FLAW_CUT,
        FLAW_LEN_SWITCH
    } flaw_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic [7:0]  data_byte = 8'h00;
    logic [15:0] payload_length = 16'h0000;
    logic        last_byte = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [7:0]  name_byte;
    logic        byte_valid;
    logic        done_res;
    logic        found;
    logic        cfg_write_en = 1'b0;
    logic [7:0]  cfg_write_data = 8'h00;

    sni_scoreboard sni_sb;
    logic [7:0]    hello[$];
    bit            steady = 1'b0;
    int unsigned   cycles;
    int unsigned   bytes_sent = 0;
    int unsigned   packets_sent = 0;

    // result side as seen at each falling edge, ahead of the next rising edge
    logic          seen_valid = 1'b0;
    logic          seen_stall = 1'b0;
    logic [7:0]    seen_name = 8'h00;
    logic          seen_bv = 1'b0;
    logic          seen_done = 1'b0;
    logic          seen_found = 1'b0;

    tls_client_hello_sni_extract_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .data_byte      (data_byte),
        .payload_length (payload_length),
        .last_byte      (last_byte),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .name_byte      (name_byte),
        .byte_valid     (byte_valid),
        .done_res       (done_res),
        .found          (found),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    always #6 clk = ~clk;

    // outputs settle long before the falling edge, so sample there
    always @(negedge clk)
    begin
        seen_valid = result_valid;
        seen_stall = result_stall;
        seen_name  = name_byte;
        seen_bv    = byte_valid;
        seen_done  = done_res;
        seen_found = found;
    end

    // a result transaction completes at the edge after a sample with valid and no stall;
    // the stall for the next cycle is drawn here too, held low in the steady stretch
    always @(posedge clk)
    begin
        if (rst_n && seen_valid && !seen_stall)
            sni_sb.check_result(seen_name, seen_bv, seen_done, seen_found);
        result_stall <= rst_n && !steady && ($urandom_range(99) < 7);
    end

    // watchdog on a plain cycle count
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles with %0d results outstanding",
                 cycles, sni_sb.pending());
        $display("*** FAILED ***");
        $finish;
    end

    // one byte transaction; entered and left just after a rising edge
    task automatic send_byte(input logic [7:0] value, input logic [15:0] plen,
                             input logic last);
        bit taken;
        // random idle cycles ahead of the byte, none in the steady stretch
        while (!steady && $urandom_range(99) < 7)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid     <= 1'b1;
        data_byte      <= value;
        payload_length <= plen;
        last_byte      <= last;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !item_stall;
            @(posedge clk);
        end
        sni_sb.note_byte(value, plen, last);
        bytes_sent++;
    endtask

    // sends the whole hello queue; the length may switch to a second value mid-packet
    task automatic send_packet(input logic [15:0] plen, input logic [15:0] alt_plen,
                               input int unsigned switch_at);
        for (int i = 0; i < hello.size(); i++)
            send_byte(hello[i], (i >= switch_at) ? alt_plen : plen, i == hello.size() - 1);
        packets_sent++;
    endtask

    // hold the sender until every expected result has come out
    task automatic settle();
        item_valid <= 1'b0;
        while (sni_sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // register write only while the block is empty
    task automatic set_max_name_len(input logic [7:0] value);
        settle();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        sni_sb.set_max_name_len(value);
    endtask

    task automatic push16(input int unsigned value);
        hello.push_back(value[15:8]);
        hello.push_back(value[7:0]);
    endtask

    // non-name extension with a short random body
    task automatic push_other_extension();
        int unsigned body;
        body = $urandom_range(6);
        push16($urandom_range(1, 65535));
        push16(body);
        repeat (body) hello.push_back(8'($urandom));
    endtask

    // well-formed client hello with random content; big_suites stretches the
    // cipher suite list so the later offsets land near the top of the length range
    task automatic make_client_hello(input bit big_suites);
        int unsigned sid_len;
        int unsigned cs_len;
        int unsigned name_len;
        int unsigned zero_at;
        int unsigned ext_len_at;
        int unsigned ext_start;
        int unsigned ext_total;
        int unsigned pick;
        hello.delete();
        // record header then handshake header, random and version bytes up to the session id
        hello.push_back(REC_HANDSHAKE);
        repeat (4) hello.push_back(8'($urandom));
        hello.push_back(HS_CLIENT_HELLO);
        repeat (SID_OFFSET - HS_TYPE_OFFSET - 1) hello.push_back(8'($urandom));
        sid_len = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(8);
        hello.push_back(8'(sid_len));
        repeat (sid_len) hello.push_back(8'($urandom));
        if (big_suites)
            cs_len = 64000;
        else
            cs_len = ($urandom_range(19) == 0) ? $urandom_range(600) : $urandom_range(8);
        push16(cs_len);
        repeat (cs_len) hello.push_back(8'($urandom));
        hello.push_back(8'($urandom_range(3)));
        repeat (hello[hello.size() - 1]) hello.push_back(8'($urandom));
        ext_len_at = hello.size();
        push16(0);
        ext_start = hello.size();
        repeat ($urandom_range(3)) push_other_extension();
        if ($urandom_range(9) != 0)
        begin
            // empty names, names past the clamp, and short everyday names
            pick = $urandom_range(19);
            if (pick == 0)
                name_len = 0;
            else if (pick == 1)
                name_len = $urandom_range(200, 300);
            else
                name_len = $urandom_range(1, 12);
            push16(EXT_SERVER_NAME);
            push16(name_len + 5);
            push16(name_len + 3);
            hello.push_back(8'h00);
            push16(name_len);
            // an embedded zero now and then ends the copy early
            zero_at = ($urandom_range(7) == 0) ? $urandom_range(name_len) : name_len;
            for (int k = 0; k < name_len; k++)
                hello.push_back((k == zero_at) ? 8'h00 : 8'($urandom_range(1, 255)));
        end
        repeat ($urandom_range(2)) push_other_extension();
        ext_total = hello.size() - ext_start;
        hello[ext_len_at]     = ext_total[15:8];
        hello[ext_len_at + 1] = ext_total[7:0];
    endtask

    // mostly hellos, the rest short noise packets; half of all packets damaged in one way
    task automatic random_packet();
        logic [15:0] plen;
        logic [15:0] alt_plen;
        int unsigned switch_at;
        int unsigned idx;
        int unsigned cut;
        flaw_t       flaw;
        if ($urandom_range(99) < 80)
        begin
            make_client_hello(1'b0);
            repeat ($urandom_range(3)) hello.push_back(8'($urandom));
            plen = 16'(hello.size());
        end
        else
        begin
            hello.delete();
            repeat ($urandom_range(1, 40)) hello.push_back(8'($urandom));
            if ($urandom_range(1))
                hello[0] = REC_HANDSHAKE;
            plen = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(60));
        end
        alt_plen = plen;
        switch_at = hello.size();
        flaw = $urandom_range(1) ? FLAW_NONE : flaw_t'($urandom_range(1, 5));
        case (flaw)
            FLAW_FLIP:
            begin
                idx = $urandom_range(hello.size() - 1);
                hello[idx] = hello[idx] ^ 8'($urandom_range(1, 255));
            end
            FLAW_ANY_LEN:
                plen = 16'($urandom);
            // just under the real size lands right on the bound checks
            FLAW_SHORT_LEN:
                plen = plen - 16'($urandom_range(1, 3));
            FLAW_CUT:
            begin
                cut = $urandom_range(1, hello.size());
                if ($urandom_range(1) && hello.size() > 8)
                    cut = hello.size() - $urandom_range(1, 8);
                hello = hello[0:cut - 1];
            end
            FLAW_LEN_SWITCH:
            begin
                alt_plen = 16'($urandom);
                switch_at = $urandom_range(hello.size() - 1);
            end
            default:
                ;
        endcase
        send_packet(plen, alt_plen, switch_at);
    endtask

    initial
    begin
        logic [7:0] settings [PHASES];
        settings = '{MAX_NAME_RESET, 8'd0, 8'd255, 8'd1, 8'($urandom_range(2, 254)), 8'd7};
        sni_sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one-, two- and three-byte packets: short length, smallest accepted length,
        // wrong record type, extreme lengths, bytes after a failure, undecided end
        send_byte(REC_HANDSHAKE, MIN_PAYLOAD_LEN, 1'b1);
        send_byte(REC_HANDSHAKE, MIN_PAYLOAD_LEN + 16'd1, 1'b1);
        send_byte(REC_HANDSHAKE, 16'hFFFF, 1'b0);
        send_byte(8'h00, 16'hFFFF, 1'b1);
        send_byte(8'hFF, 16'h0000, 1'b0);
        send_byte(REC_HANDSHAKE, 16'h0000, 1'b0);
        send_byte(REC_HANDSHAKE, 16'h0000, 1'b1);
        send_byte(8'h17, 16'd100, 1'b1);
        send_byte(REC_HANDSHAKE, 16'h8000, 1'b0);
        send_byte(8'h02, 16'h8000, 1'b0);
        send_byte(8'hA5, 16'h7FFF, 1'b1);

        // random phases, each with its own max_name_length; the write waits for an
        // empty block, which also gives the sender a full pause at every boundary
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0)
                set_max_name_len(settings[ph]);
            steady = (ph == 3);
            while (bytes_sent < ITEM_TARGET * (ph + 1) / PHASES)
                random_packet();
        end
        steady = 1'b0;
        settle();

        $display("sent %0d packets, %0d bytes (%0d parsed) over name limits 200, 0, 255, 1, %0d, 7",
                 packets_sent, bytes_sent, sni_sb.parsed_bytes, settings[4]);
        $display("checked %0d results: %0d names found, %0d searches failed, %0d name bytes",
                 sni_sb.checked, sni_sb.names_found, sni_sb.searches_failed,
                 sni_sb.name_chars);
        if (sni_sb.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
sv/tlsni_pkg.sv
sv/tlsni_step.sv
sv/tls_client_hello_sni_extract_core.sv
tb/sv/sni_scoreboard_pkg.sv
tb/sv/tls_client_hello_sni_extract_core_test.sv
